// ===== hdl/spq_pkg.sv =====
// Shared constants and types for the sorted priority queue.
package spq_pkg;

  // Default sizes
  localparam int unsigned CapacityDef     = 64;
  localparam int unsigned PriorityBitsDef = 16;
  localparam int unsigned DataBitsDef     = 32;

  // Command codes
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cell shift control handed down the chain
  typedef struct packed {
    logic ins_en;   // an insert happens this cycle
    logic prev_le;  // lower neighbor keeps its entry (holds priority <= key)
  } cell_ctrl_t;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue top level: cell chain, fill count and result register.
// A result strobes on done_o in the cycle after its command is accepted.
// Throughput: one command per cycle; busy_o stays low, the per-cell compare and
//   the one-step shift of the cell chain finish within the accepting cycle.
// Reset clears the fill count and the result strobe; slot contents are left
//   as they are and are never read before being written.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY      = spq_pkg::CapacityDef,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int unsigned DATA_BITS     = spq_pkg::DataBitsDef,
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     cmd_i,
  input  logic [PRIORITY_BITS-1:0] priority_req_i,
  input  logic [DATA_BITS-1:0]     entry_data_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [DATA_BITS-1:0]     out_data_o,
  output logic [CNT_W-1:0]         occupancy_o
);

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 done_q;
  spq_pkg::status_e     status_q, status_d;
  logic [DATA_BITS-1:0] out_data_q, out_data_d;

  logic accept, full, empty, enq_ok, deq_ok;

  logic [PRIORITY_BITS-1:0] cell_pri  [CAPACITY];
  logic [DATA_BITS-1:0]     cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_le;
  logic [DATA_BITS-1:0]     top_data;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign empty  = (count_q == '0);
  assign enq_ok = accept && (cmd_i == spq_pkg::CMD_ENQ) && !full;
  assign deq_ok = accept && (cmd_i == spq_pkg::CMD_DEQ) && !empty;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::cell_ctrl_t      ctrl;
    logic [PRIORITY_BITS-1:0] nb_pri;
    logic [DATA_BITS-1:0]     nb_data;

    assign ctrl.ins_en = enq_ok;
    if (i == 0) begin : g_first
      assign ctrl.prev_le = 1'b1;
      assign nb_pri       = priority_req_i;
      assign nb_data      = entry_data_i;
    end else begin : g_rest
      assign ctrl.prev_le = cell_le[i-1];
      assign nb_pri       = cell_pri[i-1];
      assign nb_data      = cell_data[i-1];
    end

    spq_cell #(
      .IDX          (i),
      .CNT_W        (CNT_W),
      .PRIORITY_BITS(PRIORITY_BITS),
      .DATA_BITS    (DATA_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .key_i     (priority_req_i),
      .new_data_i(entry_data_i),
      .nb_pri_i  (nb_pri),
      .nb_data_i (nb_data),
      .le_o      (cell_le[i]),
      .pri_o     (cell_pri[i]),
      .data_o    (cell_data[i])
    );
  end

  // Last live entry: one-hot AND-OR over the cells
  always_comb begin
    top_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      top_data = top_data | (cell_data[i] & {DATA_BITS{count_q == CNT_W'(i + 1)}});
    end
  end

  // Fill count and result beat
  always_comb begin
    count_d    = count_q;
    status_d   = spq_pkg::ST_DONE;
    out_data_d = '0;
    if (cmd_i == spq_pkg::CMD_ENQ) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        count_d    = count_q - CNT_W'(1);
        out_data_d = top_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (enq_ok || deq_ok) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      out_data_q <= out_data_d;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_data_o  = out_data_q;
  assign occupancy_o = count_q;

endmodule

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it, shifts or loads.
module spq_cell #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned CNT_W         = 7,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int unsigned DATA_BITS     = spq_pkg::DataBitsDef
) (
  input  logic                     clk_i,
  input  spq_pkg::cell_ctrl_t      ctrl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [PRIORITY_BITS-1:0] key_i,
  input  logic [DATA_BITS-1:0]     new_data_i,
  input  logic [PRIORITY_BITS-1:0] nb_pri_i,
  input  logic [DATA_BITS-1:0]     nb_data_i,
  output logic                     le_o,
  output logic [PRIORITY_BITS-1:0] pri_o,
  output logic [DATA_BITS-1:0]     data_o
);

  logic [PRIORITY_BITS-1:0] pri_q;
  logic [DATA_BITS-1:0]     data_q;
  logic                     occupied;

  // Slot holds a live entry when it sits below the fill count
  assign occupied = (count_i > CNT_W'(IDX));
  assign le_o     = occupied && (pri_q <= key_i);

  // Live entries at or below the key stay; the first slot past them loads
  // the new entry, the ones above take their lower neighbor's entry.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en && !le_o) begin
      if (ctrl_i.prev_le) begin
        pri_q  <= key_i;
        data_q <= new_data_i;
      end else begin
        pri_q  <= nb_pri_i;
        data_q <= nb_data_i;
      end
    end
  end

  assign pri_o  = pri_q;
  assign data_o = data_q;

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker #(
  parameter int unsigned CAPACITY      = spq_pkg::CapacityDef,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int unsigned DATA_BITS     = spq_pkg::DataBitsDef,
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     cmd_i,
  input logic [PRIORITY_BITS-1:0] priority_req_i,
  input logic [DATA_BITS-1:0]     entry_data_i,
  input logic                     done_o,
  input logic [1:0]               status_o,
  input logic [DATA_BITS-1:0]     out_data_o,
  input logic [CNT_W-1:0]         occupancy_o
);

  // Every accepted command gives exactly one result beat in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted command without result beat");

  a_no_extra_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result beat without accepted command");

  // Command beat carries known fields
  a_cmd_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !$isunknown({cmd_i, priority_req_i, entry_data_i}))
    else $error("command beat with unknown fields");

  // Empty report leaves the queue empty and returns no payload
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::ST_EMPTY) |-> (occupancy_o == '0 && out_data_o == '0))
    else $error("empty status with stale occupancy or payload");

  // Dropped enqueue only when full, and never any payload on an enqueue drop
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::ST_FULL) |->
      (occupancy_o == CNT_W'(CAPACITY) && out_data_o == '0))
    else $error("full status while not at capacity");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY     (CAPACITY),
  .PRIORITY_BITS(PRIORITY_BITS),
  .DATA_BITS    (DATA_BITS)
) u_spq_checker (.*);
